/* rtl/lfsa_pkg.sv */
// Types, constants and the heap ordering function of the free-segment allocator.
package lfsa_pkg;

  localparam int unsigned MaxReq = 1024;
  localparam int unsigned Slots  = 2048;

  localparam int unsigned UnitW = 31;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned LinkW = SlotW + 1;
  localparam int unsigned ReqW  = $clog2(MaxReq);
  localparam int unsigned CntW  = SlotW + 1;
  localparam int unsigned RcW   = ReqW + 1;

  localparam logic [LinkW-1:0] NoSlot = LinkW'(Slots);

  typedef enum logic [1:0] {
    RecNone,
    RecLive,
    RecGone
  } rec_state_e;

  typedef struct packed {
    logic [UnitW-1:0] size;
    logic [UnitW-1:0] lo;
    logic [SlotW-1:0] slot;
  } heap_ent_t;

  typedef struct packed {
    logic [UnitW-1:0] lo;
    logic [UnitW-1:0] hi;
  } bounds_t;

  typedef struct packed {
    logic [LinkW-1:0] prev;
    logic [LinkW-1:0] next;
  } links_t;

  typedef struct packed {
    rec_state_e       st;
    logic [SlotW-1:0] slot;
  } rec_t;

  // larger size first, lower start wins a tie
  function automatic logic better(heap_ent_t a, heap_ent_t b);
    if (a.size != b.size) return a.size > b.size;
    return a.lo < b.lo;
  endfunction

endpackage

/* rtl/lfsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lfsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/largest_free_segment_allocator_unit.sv */
// Top level of the largest-free-segment allocator: sequencer and state memories.
//
// Channels: in (cmd_i, alloc_size_i, free_request_i) and out (status_o, address_o)
// use valid/ready; the cfg channel writes total_units (cfg_data_i) and is always ready.
// Every item takes the next request number. An allocate item returns one result
// item: status 0 with the one-based start, or status 1 and address 0 when declined.
// A free item returns nothing; it merges the freed block with free neighbors.
// A split or a merge takes longer than a declined or simple item; the time is set
// by the heap sift loop, which reads one heap entry at a time over up to eleven
// levels, and by the links memory, which has a single read port.
// Throughput: one item at a time; in_ready_o is high only while the sequencer idles.
// A result waits in the output register while the next item is taken; the
// sequencer holds before its next result until out_ready_i frees that register.
// Reset and every cfg write start a clearing pass over all 2048 slots that rebuilds the
// spare slot stack, clears the request records and forms one free segment;
// no item is taken during it. total_units resets to 1024.
module largest_free_segment_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [lfsa_pkg::UnitW-1:0]  alloc_size_i,
  input  logic [lfsa_pkg::ReqW-1:0]   free_request_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [lfsa_pkg::UnitW-1:0]  address_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lfsa_pkg::UnitW-1:0]  cfg_data_i
);
  import lfsa_pkg::*;

  localparam int unsigned StW = 6;
  localparam logic [StW-1:0] S_CLR  = 6'd0,  S_IDLE = 6'd1,  S_A1  = 6'd2,  S_AEQ = 6'd3;
  localparam logic [StW-1:0] S_A2   = 6'd4,  S_A3   = 6'd5,  S_A3B = 6'd6,  S_A4  = 6'd7;
  localparam logic [StW-1:0] S_A5   = 6'd8,  S_RES  = 6'd9,  S_F0  = 6'd10, S_F1  = 6'd11;
  localparam logic [StW-1:0] S_F2   = 6'd12, S_F3   = 6'd13, S_F4  = 6'd14, S_F5  = 6'd15;
  localparam logic [StW-1:0] S_F6   = 6'd16, S_F7   = 6'd17, S_F8  = 6'd18, S_F9  = 6'd19;
  localparam logic [StW-1:0] S_FRN  = 6'd20, S_FW   = 6'd21, S_FW2 = 6'd22, S_FW3 = 6'd23;
  localparam logic [StW-1:0] S_FL   = 6'd24, S_FP1  = 6'd25, S_FP2 = 6'd26, S_FI  = 6'd27;
  localparam logic [StW-1:0] S_RM0  = 6'd28, S_RM1  = 6'd29, S_RM2 = 6'd30, S_RM3 = 6'd31;
  localparam logic [StW-1:0] S_UP   = 6'd32, S_UP1  = 6'd33, S_DN0 = 6'd34, S_DN1 = 6'd35;
  localparam logic [StW-1:0] S_DN2  = 6'd36, S_END  = 6'd37, S_LK0 = 6'd38, S_LK1 = 6'd39;
  localparam logic [StW-1:0] S_LK2  = 6'd40, S_LK3  = 6'd41;

  // control state
  logic [StW-1:0]   state_q, ret_q;
  logic [UnitW-1:0] tu_q;
  logic [SlotW-1:0] clr_q;
  logic [CntW-1:0]  hc_q, sp_q;
  logic [RcW-1:0]   rc_q;
  logic             ovq_q;

  // payload
  logic [UnitW-1:0] size_q, raddr_q, oaddr_q;
  logic [ReqW-1:0]  freq_q, req_q;
  logic             rok_q, ost_q, pf_q, nf_q;
  heap_ent_t        t_q, x_q, lc_q;
  logic [SlotW-1:0] a_q, s_q, rm_slot_q, pos_q;
  logic [LinkW-1:0] p_q, n_q, nn_q, lkl_q, lkr_q;
  bounds_t          sb_q, pb_q, nb_q;

  // memory ports
  logic heap_we, links_we, bounds_we, flag_we, hpos_we, rec_we, spare_we;
  logic [SlotW-1:0] heap_wa, heap_ra, links_wa, links_ra, bounds_wa, bounds_ra;
  logic [SlotW-1:0] flag_wa, flag_ra, hpos_wa, hpos_ra, spare_wa, spare_ra;
  logic [ReqW-1:0]  rec_wa, rec_ra;
  heap_ent_t        heap_wd, heap_rd;
  links_t           links_wd, links_rd;
  bounds_t          bounds_wd, bounds_rd;
  logic             flag_wd, flag_rd;
  logic [SlotW-1:0] hpos_wd, hpos_rd, spare_wd, spare_rd;
  rec_t             rec_wd, rec_rd;

  lfsa_ram #(.Width($bits(heap_ent_t)), .Depth(Slots)) u_heap (
    .clk_i, .we_i(heap_we), .waddr_i(heap_wa), .wdata_i(heap_wd),
    .raddr_i(heap_ra), .rdata_o(heap_rd));
  lfsa_ram #(.Width($bits(links_t)), .Depth(Slots)) u_links (
    .clk_i, .we_i(links_we), .waddr_i(links_wa), .wdata_i(links_wd),
    .raddr_i(links_ra), .rdata_o(links_rd));
  lfsa_ram #(.Width($bits(bounds_t)), .Depth(Slots)) u_bounds (
    .clk_i, .we_i(bounds_we), .waddr_i(bounds_wa), .wdata_i(bounds_wd),
    .raddr_i(bounds_ra), .rdata_o(bounds_rd));
  lfsa_ram #(.Width(1), .Depth(Slots)) u_flag (
    .clk_i, .we_i(flag_we), .waddr_i(flag_wa), .wdata_i(flag_wd),
    .raddr_i(flag_ra), .rdata_o(flag_rd));
  lfsa_ram #(.Width(SlotW), .Depth(Slots)) u_hpos (
    .clk_i, .we_i(hpos_we), .waddr_i(hpos_wa), .wdata_i(hpos_wd),
    .raddr_i(hpos_ra), .rdata_o(hpos_rd));
  lfsa_ram #(.Width(SlotW), .Depth(Slots)) u_spare (
    .clk_i, .we_i(spare_we), .waddr_i(spare_wa), .wdata_i(spare_wd),
    .raddr_i(spare_ra), .rdata_o(spare_rd));
  lfsa_ram #(.Width($bits(rec_t)), .Depth(MaxReq)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_wa), .wdata_i(rec_wd),
    .raddr_i(rec_ra), .rdata_o(rec_rd));

  // derived values
  logic [SlotW-1:0] par_w, w_slot, sp_m1;
  logic [CntW-1:0]  hc_m1;
  logic [SlotW+1:0] lidx_w, ridx_w;
  logic             lv_w, rv_w, merged_w, both_w;
  logic [UnitW-1:0] m_lo, m_hi, split_lo;
  logic             pick_l, pick_r;
  heap_ent_t        best_e;

  assign par_w    = (pos_q - 1'b1) >> 1;
  assign lidx_w   = {1'b0, pos_q, 1'b1};
  assign ridx_w   = lidx_w + 1'b1;
  assign lv_w     = lidx_w < {1'b0, hc_q};
  assign rv_w     = ridx_w < {1'b0, hc_q};
  assign sp_m1    = SlotW'(sp_q - 1'b1);
  assign hc_m1    = hc_q - 1'b1;
  assign merged_w = pf_q | nf_q;
  assign both_w   = pf_q & nf_q;
  assign w_slot   = pf_q ? p_q[SlotW-1:0] : (nf_q ? n_q[SlotW-1:0] : s_q);
  assign m_lo     = pf_q ? pb_q.lo : sb_q.lo;
  assign m_hi     = nf_q ? nb_q.hi : sb_q.hi;
  assign split_lo = t_q.lo + size_q;

  always_comb begin
    best_e = x_q;
    pick_l = 1'b0;
    pick_r = 1'b0;
    if (better(lc_q, best_e)) begin
      best_e = lc_q;
      pick_l = 1'b1;
    end
    if (rv_w && better(heap_rd, best_e)) begin
      best_e = heap_rd;
      pick_r = 1'b1;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovq_q;
  assign status_o    = ost_q;
  assign address_o   = oaddr_q;

  // memory access per state
  always_comb begin
    heap_we = 1'b0;   heap_wa = '0;   heap_wd = '0;   heap_ra = '0;
    links_we = 1'b0;  links_wa = '0;  links_wd = '0;  links_ra = '0;
    bounds_we = 1'b0; bounds_wa = '0; bounds_wd = '0; bounds_ra = '0;
    flag_we = 1'b0;   flag_wa = '0;   flag_wd = 1'b0; flag_ra = '0;
    hpos_we = 1'b0;   hpos_wa = '0;   hpos_wd = '0;   hpos_ra = '0;
    spare_we = 1'b0;  spare_wa = '0;  spare_wd = '0;  spare_ra = '0;
    rec_we = 1'b0;    rec_wa = '0;    rec_wd = '0;    rec_ra = '0;
    case (state_q)
      S_CLR: begin
        spare_we = 1'b1;
        spare_wa = clr_q;
        spare_wd = SlotW'(Slots - 1) - clr_q;
        rec_we   = {1'b0, clr_q} < (SlotW + 1)'(MaxReq);
        rec_wa   = clr_q[ReqW-1:0];
        rec_wd   = '{st: RecNone, slot: '0};
        if (clr_q == '0) begin
          bounds_we = 1'b1;
          bounds_wd = '{lo: '0, hi: tu_q};
          links_we  = 1'b1;
          links_wd  = '{prev: NoSlot, next: NoSlot};
          flag_we   = 1'b1;
          flag_wd   = tu_q != '0;
          hpos_we   = 1'b1;
          heap_we   = 1'b1;
          heap_wd   = '{size: tu_q, lo: '0, slot: '0};
        end
      end
      S_A1:  spare_ra = sp_m1;
      S_AEQ: begin
        flag_we = 1'b1;
        flag_wa = t_q.slot;
        rec_we  = 1'b1;
        rec_wa  = req_q;
        rec_wd  = '{st: RecLive, slot: t_q.slot};
      end
      S_A2:  links_ra = t_q.slot;
      S_A3: begin
        bounds_we = 1'b1;
        bounds_wa = a_q;
        bounds_wd = '{lo: t_q.lo, hi: split_lo};
        flag_we   = 1'b1;
        flag_wa   = a_q;
        rec_we    = 1'b1;
        rec_wa    = req_q;
        rec_wd    = '{st: RecLive, slot: a_q};
      end
      S_A3B: begin
        bounds_we = 1'b1;
        bounds_wa = t_q.slot;
        bounds_wd = '{lo: split_lo, hi: t_q.lo + t_q.size};
      end
      S_F0:  rec_ra = freq_q;
      S_F1: begin
        if (rec_rd.st == RecLive) begin
          rec_we  = 1'b1;
          rec_wa  = freq_q;
          rec_wd  = '{st: RecGone, slot: rec_rd.slot};
          flag_ra = rec_rd.slot;
        end
      end
      S_F2:  links_ra  = s_q;
      S_F3:  flag_ra   = links_rd.prev[SlotW-1:0];
      S_F4:  flag_ra   = n_q[SlotW-1:0];
      S_F5:  bounds_ra = s_q;
      S_F6:  bounds_ra = p_q[SlotW-1:0];
      S_F7:  bounds_ra = n_q[SlotW-1:0];
      S_F8:  links_ra  = n_q[SlotW-1:0];
      S_FW: begin
        bounds_we = 1'b1;
        bounds_wa = w_slot;
        bounds_wd = '{lo: m_lo, hi: m_hi};
        flag_we   = 1'b1;
        flag_wa   = w_slot;
        flag_wd   = 1'b1;
      end
      S_FW2: begin
        flag_we = merged_w;
        flag_wa = s_q;
      end
      S_FW3: begin
        flag_we = both_w;
        flag_wa = n_q[SlotW-1:0];
      end
      S_FP1: begin
        spare_we = merged_w && (sp_q < CntW'(Slots));
        spare_wa = sp_q[SlotW-1:0];
        spare_wd = s_q;
      end
      S_FP2: begin
        spare_we = both_w && (sp_q < CntW'(Slots));
        spare_wa = sp_q[SlotW-1:0];
        spare_wd = n_q[SlotW-1:0];
      end
      S_RM0: hpos_ra = rm_slot_q;
      S_RM1: heap_ra = hpos_rd;
      S_RM2: heap_ra = hc_m1[SlotW-1:0];
      S_UP:  heap_ra = par_w;
      S_UP1: begin
        if (better(x_q, heap_rd)) begin
          heap_we = 1'b1;
          heap_wa = pos_q;
          heap_wd = heap_rd;
          hpos_we = 1'b1;
          hpos_wa = heap_rd.slot;
          hpos_wd = pos_q;
        end
      end
      S_DN0: heap_ra = lidx_w[SlotW-1:0];
      S_DN1: heap_ra = ridx_w[SlotW-1:0];
      S_DN2: begin
        if (pick_l || pick_r) begin
          heap_we = 1'b1;
          heap_wa = pos_q;
          heap_wd = best_e;
          hpos_we = 1'b1;
          hpos_wa = best_e.slot;
          hpos_wd = pos_q;
        end
      end
      S_END: begin
        heap_we = 1'b1;
        heap_wa = pos_q;
        heap_wd = x_q;
        hpos_we = 1'b1;
        hpos_wa = x_q.slot;
        hpos_wd = pos_q;
      end
      S_LK0: links_ra = lkl_q[SlotW-1:0];
      S_LK1: begin
        links_we = 1'b1;
        links_wa = lkl_q[SlotW-1:0];
        links_wd = '{prev: links_rd.prev, next: lkr_q};
      end
      S_LK2: links_ra = lkr_q[SlotW-1:0];
      S_LK3: begin
        links_we = 1'b1;
        links_wa = lkr_q[SlotW-1:0];
        links_wd = '{prev: lkl_q, next: links_rd.next};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
      tu_q    <= UnitW'(1024);
      clr_q   <= '0;
      hc_q    <= CntW'(1);
      sp_q    <= CntW'(Slots - 1);
      rc_q    <= '0;
      ovq_q   <= 1'b0;
    end else begin
      if (ovq_q && out_ready_i) ovq_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          hc_q  <= CntW'(tu_q != '0);
          sp_q  <= CntW'(Slots - 1);
          rc_q  <= '0;
          clr_q <= clr_q + 1'b1;
          if (clr_q == SlotW'(Slots - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            size_q  <= alloc_size_i;
            freq_q  <= free_request_i;
            req_q   <= rc_q[ReqW-1:0];
            rok_q   <= 1'b0;
            raddr_q <= '0;
            if (rc_q != RcW'(MaxReq)) rc_q <= rc_q + 1'b1;
            if (cmd_i) begin
              state_q <= S_F0;
            end else if (rc_q == RcW'(MaxReq) || hc_q == '0 || alloc_size_i == '0) begin
              state_q <= S_RES;
            end else begin
              state_q <= S_A1;
            end
          end
        end
        S_A1: begin
          t_q <= heap_rd;
          if (heap_rd.size < size_q) begin
            state_q <= S_RES;
          end else if (heap_rd.size == size_q) begin
            rm_slot_q <= heap_rd.slot;
            ret_q     <= S_AEQ;
            state_q   <= S_RM0;
          end else if (sp_q == '0) begin
            state_q <= S_RES;
          end else begin
            sp_q    <= sp_q - 1'b1;
            state_q <= S_A2;
          end
        end
        S_AEQ: begin
          rok_q   <= 1'b1;
          raddr_q <= t_q.lo + 1'b1;
          state_q <= S_RES;
        end
        S_A2: begin
          a_q     <= spare_rd;
          state_q <= S_A3;
        end
        S_A3: begin
          p_q     <= links_rd.prev;
          rok_q   <= 1'b1;
          raddr_q <= t_q.lo + 1'b1;
          state_q <= S_A3B;
        end
        S_A3B: begin
          lkl_q   <= p_q;
          lkr_q   <= {1'b0, a_q};
          ret_q   <= S_A4;
          state_q <= S_LK0;
        end
        S_A4: begin
          lkl_q   <= {1'b0, a_q};
          lkr_q   <= {1'b0, t_q.slot};
          ret_q   <= S_A5;
          state_q <= S_LK0;
        end
        S_A5: begin
          x_q     <= '{size: t_q.size - size_q, lo: split_lo, slot: t_q.slot};
          pos_q   <= '0;
          ret_q   <= S_RES;
          state_q <= S_UP;
        end
        S_RES: begin
          if (!ovq_q || out_ready_i) begin
            ovq_q   <= 1'b1;
            ost_q   <= !rok_q;
            oaddr_q <= rok_q ? raddr_q : '0;
            state_q <= S_IDLE;
          end
        end
        S_F0: state_q <= S_F1;
        S_F1: begin
          s_q     <= rec_rd.slot;
          state_q <= (rec_rd.st == RecLive) ? S_F2 : S_IDLE;
        end
        S_F2: state_q <= flag_rd ? S_IDLE : S_F3;
        S_F3: begin
          p_q     <= links_rd.prev;
          n_q     <= links_rd.next;
          state_q <= S_F4;
        end
        S_F4: begin
          pf_q    <= !p_q[LinkW-1] && flag_rd;
          state_q <= S_F5;
        end
        S_F5: begin
          nf_q    <= !n_q[LinkW-1] && flag_rd;
          state_q <= S_F6;
        end
        S_F6: begin
          sb_q    <= bounds_rd;
          state_q <= S_F7;
        end
        S_F7: begin
          pb_q    <= bounds_rd;
          state_q <= S_F8;
        end
        S_F8: begin
          nb_q    <= bounds_rd;
          state_q <= S_F9;
        end
        S_F9: begin
          nn_q <= links_rd.next;
          if (pf_q) begin
            rm_slot_q <= p_q[SlotW-1:0];
            ret_q     <= S_FRN;
            state_q   <= S_RM0;
          end else begin
            state_q <= S_FRN;
          end
        end
        S_FRN: begin
          if (nf_q) begin
            rm_slot_q <= n_q[SlotW-1:0];
            ret_q     <= S_FW;
            state_q   <= S_RM0;
          end else begin
            state_q <= S_FW;
          end
        end
        S_FW:  state_q <= S_FW2;
        S_FW2: state_q <= S_FW3;
        S_FW3: state_q <= S_FL;
        S_FL: begin
          if (merged_w) begin
            // the merged run sits between p and the first segment past it
            lkl_q   <= p_q;
            lkr_q   <= both_w ? nn_q : n_q;
            ret_q   <= S_FP1;
            state_q <= S_LK0;
          end else begin
            state_q <= S_FP1;
          end
        end
        S_FP1: begin
          if (merged_w && (sp_q < CntW'(Slots))) sp_q <= sp_q + 1'b1;
          state_q <= S_FP2;
        end
        S_FP2: begin
          if (both_w && (sp_q < CntW'(Slots))) sp_q <= sp_q + 1'b1;
          state_q <= S_FI;
        end
        S_FI: begin
          if (hc_q >= CntW'(Slots)) begin
            state_q <= S_IDLE;
          end else begin
            pos_q   <= hc_q[SlotW-1:0];
            hc_q    <= hc_q + 1'b1;
            x_q     <= '{size: m_hi - m_lo, lo: m_lo, slot: w_slot};
            ret_q   <= S_IDLE;
            state_q <= S_UP;
          end
        end
        S_RM0: state_q <= S_RM1;
        S_RM1: begin
          pos_q   <= hpos_rd;
          state_q <= S_RM2;
        end
        S_RM2: begin
          if (!({1'b0, pos_q} < hc_q) || heap_rd.slot != rm_slot_q) begin
            state_q <= ret_q;
          end else begin
            hc_q    <= hc_m1;
            state_q <= ({1'b0, pos_q} == hc_m1) ? ret_q : S_RM3;
          end
        end
        S_RM3: begin
          // last entry fills the hole, then moves up or down
          x_q     <= heap_rd;
          state_q <= S_UP;
        end
        S_UP: state_q <= (pos_q == '0) ? S_DN0 : S_UP1;
        S_UP1: begin
          if (better(x_q, heap_rd)) begin
            pos_q   <= par_w;
            state_q <= S_UP;
          end else begin
            state_q <= S_DN0;
          end
        end
        S_DN0: state_q <= lv_w ? S_DN1 : S_END;
        S_DN1: begin
          lc_q    <= heap_rd;
          state_q <= S_DN2;
        end
        S_DN2: begin
          if (pick_r) begin
            pos_q   <= ridx_w[SlotW-1:0];
            state_q <= S_DN0;
          end else if (pick_l) begin
            pos_q   <= lidx_w[SlotW-1:0];
            state_q <= S_DN0;
          end else begin
            state_q <= S_END;
          end
        end
        S_END: state_q <= ret_q;
        S_LK0: state_q <= lkl_q[LinkW-1] ? S_LK2 : S_LK1;
        S_LK1: state_q <= S_LK2;
        S_LK2: state_q <= lkr_q[LinkW-1] ? ret_q : S_LK3;
        S_LK3: state_q <= ret_q;
        default: state_q <= S_IDLE;
      endcase
      if (cfg_valid_i) begin
        tu_q    <= cfg_data_i;
        clr_q   <= '0;
        state_q <= S_CLR;
      end
    end
  end

endmodule
